### src/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the 4-bit character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_PRINT    = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_DISPCTL  = 3'd2,
    CMD_SETADDR  = 3'd3,
    CMD_INIT     = 3'd4
  } cmd_code_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHARS_PER_LINE = 3'd0;
  localparam logic [2:0] CFG_LINE_COUNT     = 3'd1;
  localparam logic [2:0] CFG_LINE_ADDR_0    = 3'd2;
  localparam logic [2:0] CFG_LINE_ADDR_3    = 3'd5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  // Field widths
  localparam int COMMAND_W = 3;
  localparam int VALUE_W   = 8;
  localparam int NIBBLE_W  = 4;
  localparam int COLUMN_W  = 6;
  localparam int LINE_W    = 3;
  localparam int ADDR_W    = 7;
  localparam int NUM_LINE_ADDR = 4;

  localparam int MAX_LINES_DEFAULT = 4;

  // Instruction bytes and special characters
  localparam logic [7:0] BYTE_CLEAR   = 8'b0000_0001;
  localparam logic [7:0] BYTE_DISPCTL = 8'b0000_1000;
  localparam logic [7:0] BYTE_SETADDR = 8'b1000_0000;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Function set sequence for 4-bit mode: 3,3,3,2 then byte 0x28
  localparam int JOB_NIBBLES = 6;
  localparam logic [JOB_NIBBLES-1:0][NIBBLE_W-1:0] INIT_NIBBLES =
    {4'd8, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3};

  localparam int JOB_COUNT_W = $clog2(JOB_NIBBLES + 1);
  localparam int JOB_IDX_W   = $clog2(JOB_NIBBLES);

  localparam int QUEUE_DEPTH = 2;

  // One queued job: nibbles in send order from index 0, with RS per nibble
  typedef struct packed {
    logic [JOB_COUNT_W-1:0]                count;
    logic [JOB_NIBBLES-1:0]                rs;
    logic [JOB_NIBBLES-1:0][NIBBLE_W-1:0]  nibs;
  } job_t;

endpackage

### src/clcd_if.sv
// ----------------------------------------------------------------------------
// clcd_cmd_if / clcd_nib_if
// Valid/ready channels for commands in and bus nibbles out.
// ----------------------------------------------------------------------------
interface clcd_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [clcd_pkg::COMMAND_W-1:0]    command;
  logic [clcd_pkg::VALUE_W-1:0]      value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface clcd_nib_if;
  logic                              valid;
  logic                              ready;
  logic [clcd_pkg::NIBBLE_W-1:0]     nibble;
  logic                              reg_select;
  logic                              last;

  modport source (output valid, output nibble, output reg_select, output last,
                  input ready);
  modport sink   (input valid, input nibble, input reg_select, input last,
                  output ready);
endinterface

### src/clcd_front.sv
// ----------------------------------------------------------------------------
// clcd_front
// Accepts commands, holds the configuration and the column / line tracking,
// and turns each command into a job of nibbles for the back end.
// ----------------------------------------------------------------------------
module clcd_front #(
  parameter int MaxLines = clcd_pkg::MAX_LINES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  clcd_cmd_if.sink                        cmd,
  input  logic                            cfg_write,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output clcd_pkg::job_t                  push_job
);

  localparam int LimW = clcd_pkg::LINE_W + 1;

  logic [clcd_pkg::COLUMN_W-1:0] chars_per_line;
  logic [clcd_pkg::LINE_W-1:0]   line_count;
  logic [clcd_pkg::ADDR_W-1:0]   line_addr [clcd_pkg::NUM_LINE_ADDR];

  logic [clcd_pkg::COLUMN_W-1:0] column, column_next;
  logic [clcd_pkg::LINE_W-1:0]   next_line, next_line_next;

  logic [LimW-1:0]               line_limit;
  logic                          can_break;
  logic                          is_newline;
  logic                          wrap;
  logic [clcd_pkg::ADDR_W-1:0]   brk_addr;
  logic [7:0]                    brk_byte;
  logic [7:0]                    byte_out;
  logic                          accept;
  clcd_pkg::job_t                job;

  // Line limit is the smaller of the register and the hardware line count
  assign line_limit = ({1'b0, line_count} < LimW'(MaxLines)) ?
                      {1'b0, line_count} : LimW'(MaxLines);
  assign can_break  = {1'b0, next_line} < line_limit;
  assign is_newline = (line_count != '0) && (cmd.value == clcd_pkg::CHAR_NEWLINE);
  assign wrap       = (chars_per_line != '0) && (column == chars_per_line) && can_break;
  assign brk_addr   = next_line[2] ? '0 : line_addr[next_line[1:0]];
  assign brk_byte   = clcd_pkg::BYTE_SETADDR | {1'b0, brk_addr};

  // Build the job and the next tracking state
  always_comb begin
    job            = '0;
    byte_out       = '0;
    column_next    = column;
    next_line_next = next_line;
    unique case (cmd.command)
      clcd_pkg::CMD_PRINT: begin
        if (is_newline) begin
          if (can_break) begin
            job.count      = clcd_pkg::JOB_COUNT_W'(2);
            job.nibs[0]    = brk_byte[7:4];
            job.nibs[1]    = brk_byte[3:0];
            next_line_next = next_line + 1'b1;
            column_next    = '0;
          end
        end else if (wrap) begin
          job.count      = clcd_pkg::JOB_COUNT_W'(4);
          job.nibs[0]    = brk_byte[7:4];
          job.nibs[1]    = brk_byte[3:0];
          job.nibs[2]    = cmd.value[7:4];
          job.nibs[3]    = cmd.value[3:0];
          job.rs[3:2]    = 2'b11;
          next_line_next = next_line + 1'b1;
          column_next    = clcd_pkg::COLUMN_W'(1);
        end else begin
          job.count   = clcd_pkg::JOB_COUNT_W'(2);
          job.nibs[0] = cmd.value[7:4];
          job.nibs[1] = cmd.value[3:0];
          job.rs[1:0] = 2'b11;
          if (chars_per_line != '0 && column != '1) begin
            column_next = column + 1'b1;
          end
        end
      end
      clcd_pkg::CMD_CLEAR: begin
        byte_out       = clcd_pkg::BYTE_CLEAR;
        job.count      = clcd_pkg::JOB_COUNT_W'(2);
        job.nibs[0]    = byte_out[7:4];
        job.nibs[1]    = byte_out[3:0];
        column_next    = '0;
        next_line_next = '0;
      end
      clcd_pkg::CMD_DISPCTL: begin
        byte_out    = clcd_pkg::BYTE_DISPCTL | {5'd0, cmd.value[2:0]};
        job.count   = clcd_pkg::JOB_COUNT_W'(2);
        job.nibs[0] = byte_out[7:4];
        job.nibs[1] = byte_out[3:0];
      end
      clcd_pkg::CMD_SETADDR: begin
        byte_out    = clcd_pkg::BYTE_SETADDR | {1'b0, cmd.value[6:0]};
        job.count   = clcd_pkg::JOB_COUNT_W'(2);
        job.nibs[0] = byte_out[7:4];
        job.nibs[1] = byte_out[3:0];
      end
      clcd_pkg::CMD_INIT: begin
        job.count = clcd_pkg::JOB_COUNT_W'(clcd_pkg::JOB_NIBBLES);
        job.nibs  = clcd_pkg::INIT_NIBBLES;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  // Items that yield nothing are still taken, only when the queue has room
  assign cmd.ready  = push_ready;
  assign accept     = cmd.valid && push_ready;
  assign push_valid = cmd.valid && (job.count != '0);
  assign push_job   = job;

  // Tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      next_line <= '0;
    end else if (accept) begin
      column    <= column_next;
      next_line <= next_line_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_line <= '0;
      line_count     <= '0;
      for (int i = 0; i < clcd_pkg::NUM_LINE_ADDR; i++) begin
        line_addr[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == clcd_pkg::CFG_CHARS_PER_LINE) begin
        chars_per_line <= cfg_data[clcd_pkg::COLUMN_W-1:0];
      end else if (cfg_index == clcd_pkg::CFG_LINE_COUNT) begin
        line_count <= cfg_data[clcd_pkg::LINE_W-1:0];
      end else if (cfg_index >= clcd_pkg::CFG_LINE_ADDR_0 &&
                   cfg_index <= clcd_pkg::CFG_LINE_ADDR_3) begin
        line_addr[2'(cfg_index - clcd_pkg::CFG_LINE_ADDR_0)] <= cfg_data;
      end
    end
  end

  // A clear always restarts tracking from the top-left
  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == clcd_pkg::CMD_CLEAR |=> column == '0 && next_line == '0)
    else $error("clear did not reset column tracking");

  // A line break is only ever taken below the limit
  a_break_limit: assert property (@(posedge clk) disable iff (rst)
    accept && next_line_next != next_line && cmd.command == clcd_pkg::CMD_PRINT
      |-> can_break)
    else $error("line break past the line limit");

  // A wrap restarts the column at one character in
  a_wrap_column: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == clcd_pkg::CMD_PRINT && !is_newline && wrap
      |=> column == clcd_pkg::COLUMN_W'(1))
    else $error("column wrong after wrap");

endmodule

### src/clcd_queue.sv
// ----------------------------------------------------------------------------
// clcd_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module clcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  clcd_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output clcd_pkg::job_t pop_job
);

  localparam int PtrW = $clog2(clcd_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(clcd_pkg::QUEUE_DEPTH + 1);

  clcd_pkg::job_t  slots [clcd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push, do_pop;

  assign push_ready = fill != CntW'(clcd_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store the job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(clcd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(clcd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Fill count never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CntW'(clcd_pkg::QUEUE_DEPTH))
    else $error("queue fill count out of range");

  // Empty queue has aligned pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree when empty");

  // Push with room but no pop raises the fill count
  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> fill == $past(fill) + 1'b1)
    else $error("queue fill count not advanced");

endmodule

### src/clcd_back.sv
// ----------------------------------------------------------------------------
// clcd_back
// Steps through each job one nibble per cycle, unless nib.ready stalls it, into a registered output.
// ----------------------------------------------------------------------------
module clcd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  clcd_pkg::job_t pop_job,
  clcd_nib_if.source     nib
);

  clcd_pkg::job_t                  cur;
  logic                            cur_valid;
  logic [clcd_pkg::JOB_IDX_W-1:0]  idx;
  logic                            advance, emit, finish;
  logic                            is_last;

  assign advance   = !nib.valid || nib.ready;
  assign emit      = advance && cur_valid;
  assign is_last   = clcd_pkg::JOB_COUNT_W'(idx) == (cur.count - 1'b1);
  assign finish    = emit && is_last;
  assign pop_ready = !cur_valid || finish;

  // Hold the job in progress
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
    end
  end

  // Step the nibble index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop_valid && pop_ready) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (finish) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (emit) begin
      idx <= idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nib.valid <= 1'b0;
    end else if (advance) begin
      nib.valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nib.nibble     <= cur.nibs[idx];
      nib.reg_select <= cur.rs[idx];
      nib.last       <= is_last;
    end
  end

  // Index stays inside the job
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> clcd_pkg::JOB_COUNT_W'(idx) < cur.count)
    else $error("nibble index past job length");

  // Jobs are always whole bytes or the init run
  a_job_len: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.count == clcd_pkg::JOB_COUNT_W'(2) ||
                  cur.count == clcd_pkg::JOB_COUNT_W'(4) ||
                  cur.count == clcd_pkg::JOB_COUNT_W'(clcd_pkg::JOB_NIBBLES))
    else $error("job length invalid");

  // Every emitted nibble shows up on the output
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> nib.valid)
    else $error("emitted nibble lost");

endmodule

### src/char_lcd_text_nibble_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_text_nibble_sequencer
// Command-to-nibble front end for a 4-bit character LCD bus.
// ----------------------------------------------------------------------------
// Each accepted command becomes 0, 2, 4 or 6 nibbles on the output channel,
// high nibble first, with reg_select high for printed characters and last
// marking the final nibble of a command. The output runs at one nibble per
// cycle while nib.ready does not stall it; a character with a line wrap gives
// 4 nibbles and initialize gives 6. The input takes one command per cycle
// while the two-entry job queue has room; commands that produce nothing pass
// straight through. Configuration must be written while the block is idle.
module char_lcd_text_nibble_sequencer #(
  parameter int MaxLines = clcd_pkg::MAX_LINES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  clcd_cmd_if.sink                         cmd,
  clcd_nib_if.source                       nib,
  input  logic                             cfg_write,
  input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           push_valid, push_ready;
  clcd_pkg::job_t push_job;
  logic           pop_valid, pop_ready;
  clcd_pkg::job_t pop_job;

  // Classify commands and track position
  clcd_front #(.MaxLines(MaxLines)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Decouple front and back
  clcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Drive the nibble bus
  clcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .nib       (nib)
  );

endmodule
